### rtl/core/uapse_pkg.sv
package uapse_pkg;

  localparam logic [7:0] DashByte  = 8'h2D;
  localparam logic [7:0] Mask2Lead = 8'hE0;
  localparam logic [7:0] Code2Lead = 8'hC0;
  localparam logic [7:0] Mask3Lead = 8'hF0;
  localparam logic [7:0] Code3Lead = 8'hE0;
  localparam logic [7:0] Mask4Lead = 8'hF8;
  localparam logic [7:0] Code4Lead = 8'hF0;
  localparam logic [7:0] MaskCont  = 8'hC0;
  localparam logic [7:0] CodeCont  = 8'h80;

  // decoder answer for one byte against the open sequence
  typedef struct packed {
    logic [2:0] cnt;       // number of results, 0 to 4
    logic [7:0] fin_byte;  // byte of the final result, dashes before it
    logic [1:0] pc_d;      // next pending count
    logic [2:0] el_d;      // next expected length
  } dec_t;

  // what the result stage loads for one transaction
  typedef struct packed {
    logic [2:0] cnt;
    logic [7:0] fin_byte;
    logic       last;
  } res_t;

  // total length of a sequence opened by b, 0 if b is no lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & Mask2Lead) == Code2Lead) begin
      len = 3'd2;
    end else if ((b & Mask3Lead) == Code3Lead) begin
      len = 3'd3;
    end else if ((b & Mask4Lead) == Code4Lead) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

### rtl/core/uapse_decode.sv
module uapse_decode (
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  logic [1:0]     pc_i,
  input  logic [2:0]     el_i,
  output uapse_pkg::dec_t dec_o
);

  logic       cont;
  logic       alnum;
  logic       fresh;
  logic [2:0] pc1;
  logic [2:0] flush;
  logic [2:0] len;

  always_comb begin
    cont  = (byte_i & uapse_pkg::MaskCont) == uapse_pkg::CodeCont;
    alnum = byte_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    pc1   = {1'b0, pc_i} + 3'd1;
    len   = uapse_pkg::lead_length(byte_i);
    fresh = 1'b1;
    flush = 3'd0;
    dec_o.cnt      = 3'd0;
    dec_o.fin_byte = uapse_pkg::DashByte;
    dec_o.pc_d     = 2'd0;
    dec_o.el_d     = 3'd0;

    if (pc_i != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (pc1 >= el_i) begin
          dec_o.cnt = 3'd1;
        end else if (last_i) begin
          dec_o.cnt = pc1;
        end else begin
          dec_o.pc_d = pc1[1:0];
          dec_o.el_d = el_i;
        end
      end else begin
        flush = {1'b0, pc_i};
      end
    end

    if (fresh) begin
      if (alnum) begin
        dec_o.cnt      = flush + 3'd1;
        dec_o.fin_byte = byte_i;
      end else if (byte_i[7] == 1'b0) begin
        dec_o.cnt = flush + 3'd1;
      end else if (len != 3'd0 && !last_i) begin
        // lead byte opens a sequence, only held bytes drain now
        dec_o.cnt  = flush;
        dec_o.pc_d = 2'd1;
        dec_o.el_d = len;
      end else begin
        dec_o.cnt = flush + 3'd1;
      end
    end
  end

endmodule

### rtl/core/uapse_drain.sv
module uapse_drain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_en_i,
  input  uapse_pkg::res_t load_i,
  input  logic            out_ready_i,
  output logic            free_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            name_end_o
);

  logic       valid_q, valid_d;
  logic [2:0] rem_q, rem_d;
  logic [7:0] fin_q;
  logic       last_q;
  logic       final_one;

  assign final_one = rem_q == 3'd1;
  assign free_o    = !valid_q || (out_ready_i && final_one);

  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    if (load_en_i) begin
      valid_d = 1'b1;
      rem_d   = load_i.cnt;
    end else if (valid_q && out_ready_i) begin
      if (final_one) begin
        valid_d = 1'b0;
      end else begin
        rem_d = rem_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      fin_q  <= load_i.fin_byte;
      last_q <= load_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = final_one ? fin_q : uapse_pkg::DashByte;
  assign run_last_o  = final_one;
  assign name_end_o  = final_one && last_q;

endmodule

### rtl/core/utf8_aware_path_slug_encoder.sv
// an accepted byte passes the input register and then the result register before its first result appears
// throughput: one input byte per cycle while each byte gives at most one result and out_ready_i is high
// a byte that gives k results (k up to 4) holds the result register until all k are taken
// reset: rst_ni low clears the input and result valid flags and the open sequence state
module utf8_aware_path_slug_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       name_end_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // open sequence state: held byte count and total length
  logic [1:0] pc_q, pc_d;
  logic [2:0] el_q, el_d;

  uapse_pkg::dec_t dec;
  uapse_pkg::res_t res;
  logic            res_free;
  logic            adv;
  logic            load_en;

  uapse_decode u_decode (
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .pc_i   (pc_q),
    .el_i   (el_q),
    .dec_o  (dec)
  );

  // a byte that gives no result only moves the state, so it never waits
  assign adv        = in_valid_q && ((dec.cnt == 3'd0) || res_free);
  assign load_en    = adv && (dec.cnt != 3'd0);
  assign in_ready_o = !in_valid_q || adv;

  assign res.cnt      = dec.cnt;
  assign res.fin_byte = dec.fin_byte;
  assign res.last     = in_last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    pc_d       = pc_q;
    el_d       = el_q;
    if (adv) begin
      in_valid_d = 1'b0;
      pc_d       = dec.pc_d;
      el_d       = dec.el_d;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pc_q       <= 2'd0;
      el_q       <= 3'd0;
    end else begin
      in_valid_q <= in_valid_d;
      pc_q       <= pc_d;
      el_q       <= el_d;
    end
  end

  // payload capture on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  uapse_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (load_en),
    .load_i      (res),
    .out_ready_i (out_ready_i),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .name_end_o  (name_end_o)
  );

  // the end of a path always closes any open sequence
  a_path_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (pc_q == 2'd0 && el_q == 3'd0))
    else $error("state not cleared after last byte");

  // an open sequence has fewer held bytes than its length, and a length of 2 to 4
  a_state_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q != 2'd0) |-> ({1'b0, pc_q} < el_q && el_q >= 3'd2 && el_q <= 3'd4))
    else $error("inconsistent sequence state");

  // no open sequence means no expected length
  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == 2'd0) |-> (el_q == 3'd0))
    else $error("expected length without open sequence");

endmodule
